/* hw/rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked concurrent assertion wrappers used by fpf_ctrl.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Checked only while out of reset
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define ASSERT_CLK(label, clk, rst_n, prop, msg)
`define ASSERT_ALWAYS(label, clk, prop, msg)

`endif

`endif

/* hw/rtl/fpf_pkg.sv */
// ----------------------------------------------------------------------------
// fpf_pkg
// Shared types and constants of the fader position filter.
// ----------------------------------------------------------------------------
package fpf_pkg;

    localparam int POS_BITS       = 8;
    localparam int COUNT_BITS     = 8;
    localparam int CFG_INDEX_BITS = 3;
    localparam int DIV_STEPS      = POS_BITS;
    localparam int STEP_CNT_BITS  = $clog2(DIV_STEPS);

    localparam logic [CFG_INDEX_BITS-1:0] REG_TRACK_MIN    = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_TRACK_MAX    = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SMALL_STEP   = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_BIG_STEP     = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_REPEAT_COUNT = 3'd4;

    localparam int RESET_TRACK_MIN  = 15;
    localparam int RESET_TRACK_MAX  = 4086;
    localparam int RESET_SMALL_STEP = 5;
    localparam int RESET_BIG_STEP   = 25;
    localparam logic [COUNT_BITS-1:0] RESET_REPEAT_COUNT = 8'd5;

    typedef struct packed {
        logic load;
        logic prep;
        logic div_load;
        logic div_step;
        logic commit;
    } fpf_cmd_t;

    typedef struct packed {
        logic below_small;
        logic empty_track;
        logic out_free;
    } fpf_status_t;

endpackage

/* hw/rtl/fpf_datapath.sv */
// ----------------------------------------------------------------------------
// fpf_datapath
// Config registers, filter state, clamp/scale arithmetic, restoring divider
// and output register.
// ----------------------------------------------------------------------------
module fpf_datapath #(
    parameter int SAMPLE_BITS = 12
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write,
    input  logic [fpf_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [SAMPLE_BITS-1:0]         cfg_data,
    input  logic [SAMPLE_BITS-1:0]         sample,
    input  fpf_pkg::fpf_cmd_t              cmd,
    output fpf_pkg::fpf_status_t           status,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [fpf_pkg::POS_BITS-1:0]   position,
    output logic                           changed
);
    import fpf_pkg::*;

    localparam int W = SAMPLE_BITS;

    logic [W-1:0]          track_min_reg;
    logic [W-1:0]          track_max_reg;
    logic [W-1:0]          small_step_reg;
    logic [W-1:0]          big_step_reg;
    logic [COUNT_BITS-1:0] repeat_count_reg;

    logic [W-1:0]          accepted_sample_reg;
    logic [POS_BITS-1:0]   accepted_position_reg;
    logic [COUNT_BITS-1:0] ticks_left_reg;

    logic [W-1:0]          sample_reg;
    logic                  small_reg;
    logic                  big_reg;
    logic                  empty_reg;
    logic [W-1:0]          offset_reg;
    logic [W-1:0]          den_reg;

    logic [W:0]            rem_reg;
    logic [W:0]            divisor_reg;
    logic [POS_BITS-1:0]   low_reg;
    logic [POS_BITS-1:0]   quot_reg;

    logic                  out_valid_reg;
    logic [POS_BITS-1:0]   position_reg;
    logic                  changed_reg;

    logic [W-1:0]          diff;
    logic [W-1:0]          clamped;
    logic [W+7:0]          num;
    logic [W+8:0]          dividend;
    logic [W+1:0]          trial;
    logic                  trial_ge;
    logic [POS_BITS-1:0]   new_pos;

    // prep stage: distance, flags, clamped offset
    always_comb
    begin
        if (accepted_sample_reg > sample_reg)
            diff = accepted_sample_reg - sample_reg;
        else
            diff = sample_reg - accepted_sample_reg;

        if (sample_reg > track_max_reg)
            clamped = track_max_reg;
        else if (sample_reg < track_min_reg)
            clamped = track_min_reg;
        else
            clamped = sample_reg;
    end

    // dividend = 2*off*255 + den, divisor = 2*den
    assign num      = {offset_reg, 8'b0} - {8'b0, offset_reg};
    assign dividend = {num, 1'b0} + {9'b0, den_reg};

    assign trial    = {rem_reg, low_reg[POS_BITS-1]};
    assign trial_ge = (trial >= {1'b0, divisor_reg});

    assign new_pos  = empty_reg ? '0 : quot_reg;

    assign status.below_small = (diff < small_step_reg);
    assign status.empty_track = (track_max_reg <= track_min_reg);
    assign status.out_free    = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            track_min_reg         <= W'(RESET_TRACK_MIN);
            track_max_reg         <= W'(RESET_TRACK_MAX);
            small_step_reg        <= W'(RESET_SMALL_STEP);
            big_step_reg          <= W'(RESET_BIG_STEP);
            repeat_count_reg      <= RESET_REPEAT_COUNT;
            accepted_sample_reg   <= '0;
            accepted_position_reg <= '0;
            ticks_left_reg        <= RESET_REPEAT_COUNT;
            out_valid_reg         <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                unique case (cfg_index)
                    REG_TRACK_MIN:    track_min_reg    <= cfg_data;
                    REG_TRACK_MAX:    track_max_reg    <= cfg_data;
                    REG_SMALL_STEP:   small_step_reg   <= cfg_data;
                    REG_BIG_STEP:     big_step_reg     <= cfg_data;
                    REG_REPEAT_COUNT: repeat_count_reg <= cfg_data[COUNT_BITS-1:0];
                    default:          ;
                endcase
            end

            if (cmd.commit)
            begin
                out_valid_reg <= 1'b1;
                if (small_reg || new_pos == accepted_position_reg)
                begin
                    ticks_left_reg <= repeat_count_reg;
                end
                else if (big_reg || ticks_left_reg == '0)
                begin
                    ticks_left_reg        <= repeat_count_reg;
                    accepted_position_reg <= new_pos;
                    accepted_sample_reg   <= sample_reg;
                end
                else
                begin
                    ticks_left_reg <= ticks_left_reg - 1'b1;
                end
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
            sample_reg <= sample;

        if (cmd.prep)
        begin
            small_reg  <= status.below_small;
            big_reg    <= (diff > big_step_reg);
            empty_reg  <= status.empty_track;
            offset_reg <= clamped - track_min_reg;
            den_reg    <= track_max_reg - track_min_reg;
        end

        if (cmd.div_load)
        begin
            rem_reg     <= dividend[W+8:POS_BITS];
            low_reg     <= dividend[POS_BITS-1:0];
            divisor_reg <= {den_reg, 1'b0};
            quot_reg    <= '0;
        end
        else if (cmd.div_step)
        begin
            rem_reg  <= trial_ge ? (W+1)'(trial - {1'b0, divisor_reg})
                                 : trial[W:0];
            low_reg  <= {low_reg[POS_BITS-2:0], 1'b0};
            quot_reg <= {quot_reg[POS_BITS-2:0], trial_ge};
        end

        if (cmd.commit)
        begin
            if (!small_reg && new_pos != accepted_position_reg
                && (big_reg || ticks_left_reg == '0))
            begin
                position_reg <= new_pos;
                changed_reg  <= 1'b1;
            end
            else
            begin
                position_reg <= accepted_position_reg;
                changed_reg  <= 1'b0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign position  = position_reg;
    assign changed   = changed_reg;

endmodule

/* hw/rtl/fpf_ctrl.sv */
// ----------------------------------------------------------------------------
// fpf_ctrl
// Sequencer for one transaction: prep, divider load and eight divide steps
// (skipped on a small step or empty track), commit into the output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fpf_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  fpf_pkg::fpf_status_t status,
    output fpf_pkg::fpf_cmd_t    cmd
);
    import fpf_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_DIV_LOAD,
        ST_DIV_STEP,
        ST_COMMIT
    } state_t;

    state_t                   state_reg;
    state_t                   state_next;
    logic [STEP_CNT_BITS-1:0] step_cnt_reg;
    logic [STEP_CNT_BITS-1:0] step_cnt_next;

    assign in_stall = (state_reg != ST_IDLE);

    always_comb
    begin
        state_next    = state_reg;
        step_cnt_next = step_cnt_reg;
        cmd           = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.load = in_valid;
                if (in_valid)
                    state_next = ST_PREP;
            end
            ST_PREP:
            begin
                cmd.prep = 1'b1;
                if (status.below_small || status.empty_track)
                    state_next = ST_COMMIT;
                else
                    state_next = ST_DIV_LOAD;
            end
            ST_DIV_LOAD:
            begin
                cmd.div_load  = 1'b1;
                step_cnt_next = '0;
                state_next    = ST_DIV_STEP;
            end
            ST_DIV_STEP:
            begin
                cmd.div_step  = 1'b1;
                step_cnt_next = step_cnt_reg + 1'b1;
                if (step_cnt_reg == STEP_CNT_BITS'(DIV_STEPS - 1))
                    state_next = ST_COMMIT;
            end
            ST_COMMIT:
            begin
                cmd.commit = status.out_free;
                if (status.out_free)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            step_cnt_reg <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            step_cnt_reg <= step_cnt_next;
        end
    end

    `ASSERT_CLK(a_accept_to_prep, clk, rst_n, (in_valid && !in_stall) |=> (state_reg == ST_PREP), "accepted transaction did not enter prep")
    `ASSERT_CLK(a_commit_needs_room, clk, rst_n, cmd.commit |-> status.out_free, "commit while output register full")
    `ASSERT_CLK(a_div_count_start, clk, rst_n, (state_reg == ST_DIV_LOAD) |=> (step_cnt_reg == '0), "divide step count not cleared")
    `ASSERT_ALWAYS(a_one_cmd, clk, $onehot0(cmd), "more than one datapath command active")

endmodule

/* hw/rtl/fader_position_filter.sv */
// An accepted sample goes through prep, then straight to commit when the step
//   is small or the track is empty, else through the 8-step restoring divider first.
// One transaction at a time: a new sample is held off until the previous one commits;
//   a new sample is taken while the previous result still waits in the output register.
// Reset: asynchronous, active low; config registers return to defaults, stored sample
//   and position clear to zero, persistence counter loads 5.
// ----------------------------------------------------------------------------
// fader_position_filter
// Hysteresis and persistence filter that maps a raw slider sample to a
// 0..255 position.
// ----------------------------------------------------------------------------
module fader_position_filter #(
    parameter int SAMPLE_BITS = 12
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_write,
    input  logic [fpf_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [SAMPLE_BITS-1:0]             cfg_data,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [SAMPLE_BITS-1:0]             sample,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [fpf_pkg::POS_BITS-1:0]       position,
    output logic                               changed
);
    import fpf_pkg::*;

    fpf_cmd_t    cmd;
    fpf_status_t status;

    fpf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    fpf_datapath #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .sample    (sample),
        .cmd       (cmd),
        .status    (status),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .position  (position),
        .changed   (changed)
    );

endmodule
